### rtl/core/forest_path_walker_macros.svh
// assertion macros for the forest path walker checker
// no dependencies
`ifndef FOREST_PATH_WALKER_MACROS_SVH
`define FOREST_PATH_WALKER_MACROS_SVH

// same-cycle implication, off during reset
`define FPW_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("forest_path_walker assertion failed");

// next-cycle implication, off during reset
`define FPW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("forest_path_walker assertion failed");

// next-cycle implication, always checked
`define FPW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("forest_path_walker assertion failed");

`endif

### rtl/core/fpw_pkg.sv
// shared types and constants of the forest path walker
// no dependencies
package fpw_pkg;

    localparam int NODE_W = 6;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              is_query;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] depth;
    } entry_t;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] depth;
    } tbl_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] path_node;
        logic              last;
        logic              error;
    } result_t;

endpackage

### rtl/core/fpw_front.sv
// front end: classifies input beats and queues them for the back end
// depends on fpw_pkg
module fpw_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [fpw_pkg::NODE_W-1:0]   s_node_index,
    input  logic [fpw_pkg::NODE_W-1:0]   s_parent_index,
    input  logic [fpw_pkg::NODE_W-1:0]   s_node_depth,
    input  logic [fpw_pkg::NODE_W-1:0]   s_first_node,
    input  logic [fpw_pkg::NODE_W-1:0]   s_second_node,
    output logic                         q_valid,
    input  logic                         q_ready,
    output fpw_pkg::entry_t              q_entry
);

    localparam int PW = $clog2(fpw_pkg::QUEUE_DEPTH);
    localparam int CNTW = $clog2(fpw_pkg::QUEUE_DEPTH + 1);

    fpw_pkg::entry_t queue_mem [fpw_pkg::QUEUE_DEPTH];
    fpw_pkg::entry_t in_entry;

    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            push, pop;

    always_comb begin
        in_entry.is_query = (s_func == fpw_pkg::FUNC_QUERY);
        if (s_func == fpw_pkg::FUNC_QUERY) begin
            in_entry.node_a = s_first_node;
            in_entry.node_b = s_second_node;
            in_entry.depth  = '0;
        end else begin
            in_entry.node_a = s_node_index;
            in_entry.node_b = s_parent_index;
            in_entry.depth  = s_node_depth;
        end
    end

    assign s_ready = (count_reg != CNTW'(fpw_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = queue_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(fpw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(fpw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

### rtl/core/fpw_back.sv
// back end: parent/depth tables and the path climbing sequencer
// depends on fpw_pkg
module fpw_back #(
    parameter int NODES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  fpw_pkg::entry_t   q_entry,
    output logic              m_valid,
    input  logic              m_ready,
    output fpw_pkg::result_t  m_result
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES);
    localparam int XW = fpw_pkg::NODE_W + 1;
    localparam logic [XW-1:0] NODES_X = XW'(NODES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_STEP   = 2'd2;

    fpw_pkg::tbl_word_t tbl_mem [NODES];

    logic [1:0]                 state_reg, state_next;
    logic [fpw_pkg::NODE_W-1:0] c1_reg, c1_next;
    logic [fpw_pkg::NODE_W-1:0] c2_reg, c2_next;
    logic [CW-1:0]              climbs_reg, climbs_next;
    fpw_pkg::tbl_word_t         rd1_reg, rd2_reg;
    logic                       in1_reg, in2_reg;
    logic                       out_valid_reg, out_valid_next;
    fpw_pkg::result_t           out_reg, out_next;

    logic                       wr_en;
    logic                       rd_en;
    logic                       out_free;
    logic [fpw_pkg::NODE_W-1:0] d1, d2, p1, p2;

    function automatic logic in_range(input logic [fpw_pkg::NODE_W-1:0] n);
        in_range = ({1'b0, n} < NODES_X);
    endfunction

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;
    assign wr_en    = q_valid && q_ready && !q_entry.is_query && in_range(q_entry.node_a);
    assign rd_en    = (state_reg == ST_LOOKUP);

    assign d1 = in1_reg ? rd1_reg.depth : '0;
    assign d2 = in2_reg ? rd2_reg.depth : '0;
    assign p1 = in1_reg ? rd1_reg.parent : c1_reg;
    assign p2 = in2_reg ? rd2_reg.parent : c2_reg;

    always_comb begin
        state_next     = state_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        climbs_next    = climbs_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_entry.is_query) begin
                    c1_next     = q_entry.node_a;
                    c2_next     = q_entry.node_b;
                    climbs_next = '0;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (c1_reg == c2_reg) begin
                        out_next   = '{path_node: c1_reg, last: 1'b1, error: 1'b0};
                        state_next = ST_IDLE;
                    end else if ((d1 == '0 && d2 == '0) || climbs_reg >= CW'(NODES - 1)) begin
                        out_next   = '{path_node: '0, last: 1'b1, error: 1'b1};
                        state_next = ST_IDLE;
                    end else if (d1 < d2) begin
                        out_next    = '{path_node: c2_reg, last: 1'b0, error: 1'b0};
                        c2_next     = p2;
                        climbs_next = climbs_reg + 1'b1;
                        state_next  = ST_LOOKUP;
                    end else begin
                        out_next    = '{path_node: c1_reg, last: 1'b0, error: 1'b0};
                        c1_next     = p1;
                        climbs_next = climbs_reg + 1'b1;
                        state_next  = ST_LOOKUP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            c1_reg        <= '0;
            c2_reg        <= '0;
            climbs_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            c1_reg        <= c1_next;
            c2_reg        <= c2_next;
            climbs_reg    <= climbs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[q_entry.node_a[AW-1:0]] <= '{parent: q_entry.node_b, depth: q_entry.depth};
        end
        if (rd_en) begin
            rd1_reg <= tbl_mem[c1_reg[AW-1:0]];
            rd2_reg <= tbl_mem[c2_reg[AW-1:0]];
            in1_reg <= in_range(c1_reg);
            in2_reg <= in_range(c2_reg);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

### rtl/core/forest_path_walker.sv
// write beat: written to the table as the back end takes it; query: per result, a table read
// (LOOKUP), then a step (STEP) that waits on a stalled output; up to NODES results per query
// first result: query beat goes through the queue, IDLE, LOOKUP and STEP into the output reg
// a 2-entry queue between front and back keeps input accepted during a walk
// aresetn is synchronous, active low; it clears control state, tables stay undefined
module forest_path_walker #(
    parameter int NODES = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [fpw_pkg::NODE_W-1:0]   s_node_index,
    input  logic [fpw_pkg::NODE_W-1:0]   s_parent_index,
    input  logic [fpw_pkg::NODE_W-1:0]   s_node_depth,
    input  logic [fpw_pkg::NODE_W-1:0]   s_first_node,
    input  logic [fpw_pkg::NODE_W-1:0]   s_second_node,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fpw_pkg::NODE_W-1:0]   m_path_node,
    output logic                         m_last,
    output logic                         m_error
);

    logic             q_valid;
    logic             q_ready;
    fpw_pkg::entry_t  q_entry;
    fpw_pkg::result_t m_result;

    fpw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_node_index   (s_node_index),
        .s_parent_index (s_parent_index),
        .s_node_depth   (s_node_depth),
        .s_first_node   (s_first_node),
        .s_second_node  (s_second_node),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_entry        (q_entry)
    );

    fpw_back #(
        .NODES (NODES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_path_node = m_result.path_node;
    assign m_last      = m_result.last;
    assign m_error     = m_result.error;

endmodule

### rtl/core/forest_path_walker_checker.sv
// port-level checks of the forest path walker, bound to the top level
// depends on fpw_pkg and forest_path_walker_macros.svh
`include "forest_path_walker_macros.svh"

module forest_path_walker_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [fpw_pkg::NODE_W-1:0]   m_path_node,
    input logic                         m_last,
    input logic                         m_error
);

    logic [fpw_pkg::NODE_W+1:0] beat_bits;

    assign beat_bits = {m_path_node, m_last, m_error};

    // an error beat always closes its query
    `FPW_ASSERT_IMPLY(err_is_last, aclk, aresetn, m_valid && m_error, m_last)

    // an error beat carries node zero
    `FPW_ASSERT_IMPLY(err_node_zero, aclk, aresetn, m_valid && m_error, m_path_node == '0)

    // stalled result beat holds
    `FPW_ASSERT_NEXT(out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(beat_bits))

    // reset drops the result channel
    `FPW_ASSERT_NEXT_ALWAYS(reset_clears, aclk, !aresetn, !m_valid)

endmodule

bind forest_path_walker forest_path_walker_checker u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_path_node (m_path_node),
    .m_last      (m_last),
    .m_error     (m_error)
);
